@@ rtl/ddo_pkg.sv @@
// shared types, constants and helper functions of the odometry block
package ddo_pkg;

   localparam int CORDIC_STEPS_DEF = 24;
   localparam int MUL_A_W = 64;
   localparam int MUL_B_W = 34;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_METERS_PER_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE_WHEEL_BASE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE = 2'd2;
   localparam logic [15:0] SAMPLE_RATE_RESET = 16'd1000;

   localparam logic signed [31:0] PI_Q28 = 32'sd843314857;
   localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
   localparam logic signed [32:0] PI_Q28_W = 33'sd843314857;
   localparam logic signed [32:0] TWO_PI_Q28_W = 33'sd1686629713;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   localparam logic [32:0] CAP_SPEED = 33'h1_0000_0000 >> 1;
   localparam logic [32:0] CAP_TURN = 33'd843314857;
   localparam logic [32:0] CAP_TRAVEL = 33'h0_FFFF_FFFF;
   localparam logic [32:0] CAP_NONE = 33'h1_FFFF_FFFF;

   typedef struct packed {
      logic                 start;
      logic [MUL_A_W-1:0]   multiplicand;
      logic [MUL_B_W-1:0]   multiplier;
   } mul_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [MUL_P_W-1:0]   product;
   } mul_rsp_type;

   function automatic logic signed [31:0] atan_q28(input logic [4:0] idx);
      logic signed [31:0] v;
      case (idx)
         5'd0:  v = 32'sd210828714;
         5'd1:  v = 32'sd124459457;
         5'd2:  v = 32'sd65760959;
         5'd3:  v = 32'sd33381290;
         5'd4:  v = 32'sd16755422;
         5'd5:  v = 32'sd8385879;
         5'd6:  v = 32'sd4193963;
         5'd7:  v = 32'sd2097109;
         5'd8:  v = 32'sd1048571;
         5'd9:  v = 32'sd524287;
         5'd10: v = 32'sd262144;
         5'd11: v = 32'sd131072;
         5'd12: v = 32'sd65536;
         5'd13: v = 32'sd32768;
         5'd14: v = 32'sd16384;
         5'd15: v = 32'sd8192;
         5'd16: v = 32'sd4096;
         5'd17: v = 32'sd2048;
         5'd18: v = 32'sd1024;
         5'd19: v = 32'sd512;
         5'd20: v = 32'sd256;
         5'd21: v = 32'sd128;
         5'd22: v = 32'sd64;
         5'd23: v = 32'sd32;
         5'd24: v = 32'sd16;
         5'd25: v = 32'sd8;
         5'd26: v = 32'sd4;
         5'd27: v = 32'sd2;
         5'd28: v = 32'sd1;
         5'd29: v = 32'sd1;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

   // magnitude of a 34-bit signed value
   function automatic logic [33:0] mag34(input logic signed [33:0] v);
      return v[33] ? 34'(-v) : 34'(v);
   endfunction

   // apply sign to a capped magnitude and saturate to 32 bits
   function automatic logic signed [31:0] sign_sat(input logic neg, input logic [32:0] m);
      logic signed [31:0] r;
      if (neg) begin
         r = 32'(-$signed({1'b0, m}));
      end else if (m > 33'h0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else begin
         r = 32'(m);
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > 35'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -35'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

endpackage

@@ rtl/ddo_if.sv @@
// request and response channel interfaces of the odometry block
interface ddo_req_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  right_count;
   logic signed [31:0]  left_count;
   modport source (output valid, right_count, left_count, input ready);
   modport sink (input valid, right_count, left_count, output ready);
endinterface

interface ddo_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  x_position;
   logic signed [31:0]  y_position;
   logic signed [30:0]  heading;
   logic signed [31:0]  right_speed;
   logic signed [31:0]  left_speed;
   logic signed [31:0]  linear_speed;
   logic signed [31:0]  angular_speed;
   modport source (output valid, x_position, y_position, heading, right_speed, left_speed,
                   linear_speed, angular_speed, input ready);
   modport sink (input valid, x_position, y_position, heading, right_speed, left_speed,
                 linear_speed, angular_speed, output ready);
endinterface

@@ rtl/ddo_mul.sv @@
// bit-serial shift-add multiplier, one multiplier bit per cycle
module ddo_mul import ddo_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_cmd_type cmd,
   output mul_rsp_type rsp
);
   localparam int CW = $clog2(MUL_B_W);

   logic [MUL_A_W-1:0] a_ff, a_in;
   logic [MUL_A_W-1:0] hi_ff, hi_in;
   logic [MUL_B_W-1:0] lo_ff, lo_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [MUL_A_W:0]   acc;

   always_comb begin
      a_in = a_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      acc = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      if (cmd.start) begin
         a_in = cmd.multiplicand;
         hi_in = '0;
         lo_in = cmd.multiplier;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in = acc[MUL_A_W:1];
         lo_in = {acc[0], lo_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      a_ff <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.product = {hi_ff, lo_ff};
endmodule

@@ rtl/ddo_cordic.sv @@
// iterative cordic for cosine and sine of the heading, one rotation per cycle
module ddo_cordic import ddo_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [30:0] angle,
   output logic               busy,
   output logic signed [33:0] cos_out,
   output logic signed [33:0] sin_out
);
   localparam int IW = $clog2(CORDIC_STEPS);

   logic signed [33:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [31:0] z_ff, z_in, ang, at;
   logic [IW-1:0]      i_ff, i_in;
   logic               flip_ff, flip_in, busy_ff, busy_in;

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      i_in = i_ff;
      flip_in = flip_ff;
      busy_in = busy_ff;
      ang = 32'(angle);
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      at = atan_q28(5'(i_ff));
      if (start) begin
         x_in = CORDIC_GAIN_Q30;
         y_in = '0;
         i_in = '0;
         busy_in = 1'b1;
         // fold angles beyond a quarter turn by pi
         if (ang > HALF_PI_Q28) begin
            z_in = ang - PI_Q28;
            flip_in = 1'b1;
         end else if (ang < -HALF_PI_Q28) begin
            z_in = ang + PI_Q28;
            flip_in = 1'b1;
         end else begin
            z_in = ang;
            flip_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == IW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         i_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         i_ff <= i_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      flip_ff <= flip_in;
   end

   assign busy = busy_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;
endmodule

@@ rtl/differential_drive_odometry_top.sv @@
// differential drive odometry: pose and speeds from two encoder counts
// ten products run in order on the single shared serial multiplier, then one pose
// update and output load; a request is taken only while the sequencer is idle, so the
// next one waits until the last response has been loaded into the output register;
// a held response stalls the pose step and the next request
// the cordic runs alongside the first products and never adds time
// reset (synchronous, active high) clears pose, last counts and registers to defaults
module differential_drive_odometry_top import ddo_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ddo_req_if.sink               req,
   ddo_rsp_if.source             rsp,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);
   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_POSE  = 4'b1000
   } state_type;

   // products worked through in order on the shared multiplier
   typedef enum logic [3:0] {
      OP_SCALE, OP_RIGHT, OP_LEFT, OP_LIN, OP_TURN,
      OP_DTH, OP_ANG, OP_DX, OP_PX, OP_PY
   } op_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   // configuration registers
   logic [31:0] mpc_ff, iwb_ff;
   logic [15:0] sr_ff;

   // persistent odometry state
   logic [31:0]        last_r_ff, last_l_ff;
   logic signed [31:0] pose_x_ff, pose_x_in, pose_y_ff, pose_y_in;
   logic signed [30:0] pose_h_ff, pose_h_in;

   // per-request working registers
   logic signed [33:0] dr_ff, dl_ff, sum_ff, diff_ff;
   logic signed [33:0] dr_new, dl_new;
   logic [47:0]        scale_ff, scale_in;
   logic [63:0]        turn_ff, turn_in;
   logic signed [30:0] dth_ff, dth_in;
   logic [31:0]        dx_mag_ff, dx_mag_in;
   logic signed [31:0] rs_ff, rs_in, ls_ff, ls_in, lin_ff, lin_in, ang_ff, ang_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] o_x_ff, o_y_ff, o_rs_ff, o_ls_ff, o_lin_ff, o_ang_ff;
   logic signed [30:0] o_h_ff;
   logic               load_out;

   mul_cmd_type        mcmd;
   mul_rsp_type        mrsp;
   logic               mul_start;
   logic               cordic_busy;
   logic signed [33:0] cos_v, sin_v;

   logic               accept;
   logic [4:0]         shamt;
   logic [32:0]        cap;
   logic [MUL_P_W-1:0] shifted;
   logic [32:0]        capped;
   logic               term_neg;
   logic signed [34:0] term, pos_sum;
   logic signed [32:0] h_sum;

   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);

   // wrapped count deltas; left is negated so forward is positive on both
   assign dr_new = 34'($signed(req.right_count - $signed(last_r_ff)));
   assign dl_new = -34'($signed(req.left_count - $signed(last_l_ff)));

   ddo_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mcmd),
      .rsp   (mrsp)
   );

   ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .angle   (pose_h_ff),
      .busy    (cordic_busy),
      .cos_out (cos_v),
      .sin_out (sin_v)
   );

   // operand select, shift and cap for the product in hand
   always_comb begin
      mcmd.start = mul_start;
      mcmd.multiplicand = '0;
      mcmd.multiplier = '0;
      shamt = 5'd0;
      cap = CAP_NONE;
      case (op_ff)
         OP_SCALE: begin
            mcmd.multiplicand = MUL_A_W'(mpc_ff);
            mcmd.multiplier = MUL_B_W'(sr_ff);
         end
         OP_RIGHT: begin
            mcmd.multiplicand = MUL_A_W'(scale_ff);
            mcmd.multiplier = mag34(dr_ff);
            shamt = 5'd16;
            cap = CAP_SPEED;
         end
         OP_LEFT: begin
            mcmd.multiplicand = MUL_A_W'(scale_ff);
            mcmd.multiplier = mag34(dl_ff);
            shamt = 5'd16;
            cap = CAP_SPEED;
         end
         OP_LIN: begin
            mcmd.multiplicand = MUL_A_W'(scale_ff);
            mcmd.multiplier = mag34(sum_ff);
            shamt = 5'd17;
            cap = CAP_SPEED;
         end
         OP_TURN: begin
            mcmd.multiplicand = MUL_A_W'(mpc_ff);
            mcmd.multiplier = MUL_B_W'(iwb_ff);
         end
         OP_DTH: begin
            mcmd.multiplicand = turn_ff;
            mcmd.multiplier = mag34(diff_ff);
            shamt = 5'd28;
            cap = CAP_TURN;
         end
         OP_ANG: begin
            mcmd.multiplicand = MUL_A_W'(mag34(34'(dth_ff)));
            mcmd.multiplier = MUL_B_W'(sr_ff);
            shamt = 5'd12;
            cap = CAP_SPEED;
         end
         OP_DX: begin
            mcmd.multiplicand = MUL_A_W'(mpc_ff);
            mcmd.multiplier = mag34(sum_ff);
            shamt = 5'd17;
            cap = CAP_TRAVEL;
         end
         OP_PX: begin
            mcmd.multiplicand = MUL_A_W'(mag34(cos_v));
            mcmd.multiplier = MUL_B_W'(dx_mag_ff);
            shamt = 5'd30;
         end
         OP_PY: begin
            mcmd.multiplicand = MUL_A_W'(mag34(sin_v));
            mcmd.multiplier = MUL_B_W'(dx_mag_ff);
            shamt = 5'd30;
         end
         default: begin
            mcmd.multiplicand = '0;
         end
      endcase
      shifted = mrsp.product >> shamt;
      capped = (shifted > MUL_P_W'(cap)) ? cap : shifted[32:0];
      // position step: sign of travel times sign of the rotation term
      term_neg = sum_ff[33] ^ ((op_ff == OP_PX) ? cos_v[33] : sin_v[33]);
      term = term_neg ? -$signed({2'b00, capped}) : $signed({2'b00, capped});
      pos_sum = 35'((op_ff == OP_PX) ? pose_x_ff : pose_y_ff) + term;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      mul_start = 1'b0;
      scale_in = scale_ff;
      turn_in = turn_ff;
      dth_in = dth_ff;
      dx_mag_in = dx_mag_ff;
      rs_in = rs_ff;
      ls_in = ls_ff;
      lin_in = lin_ff;
      ang_in = ang_ff;
      pose_x_in = pose_x_ff;
      pose_y_in = pose_y_ff;
      pose_h_in = pose_h_ff;
      load_out = 1'b0;
      // heading update with a single wrap into plus or minus pi
      h_sum = 33'(pose_h_ff) + 33'(dth_ff);
      if (h_sum > PI_Q28_W) begin
         h_sum = h_sum - TWO_PI_Q28_W;
      end else if (h_sum < -PI_Q28_W) begin
         h_sum = h_sum + TWO_PI_Q28_W;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in = OP_SCALE;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            // rotation terms need the cordic finished
            if (!((op_ff == OP_PX) && cordic_busy)) begin
               mul_start = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (mrsp.done) begin
               case (op_ff)
                  OP_SCALE: scale_in = mrsp.product[47:0];
                  OP_RIGHT: rs_in = sign_sat(dr_ff[33], capped);
                  OP_LEFT:  ls_in = sign_sat(dl_ff[33], capped);
                  OP_LIN:   lin_in = sign_sat(sum_ff[33], capped);
                  OP_TURN:  turn_in = mrsp.product[63:0];
                  OP_DTH:   dth_in = 31'(sign_sat(diff_ff[33], capped));
                  OP_ANG:   ang_in = sign_sat(dth_ff[30], capped);
                  OP_DX:    dx_mag_in = capped[31:0];
                  OP_PX:    pose_x_in = sat35(pos_sum);
                  OP_PY:    pose_y_in = sat35(pos_sum);
                  default:  scale_in = scale_ff;
               endcase
               if (op_ff == OP_PY) begin
                  state_in = ST_POSE;
               end else begin
                  op_in = op_type'(op_ff + 1'b1);
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_POSE: begin
            // hold until the previous response has gone
            if (!rsp_valid_ff || rsp.ready) begin
               pose_h_in = 31'(h_sum);
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = load_out || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff <= OP_SCALE;
         rsp_valid_ff <= 1'b0;
         mpc_ff <= '0;
         iwb_ff <= '0;
         sr_ff <= SAMPLE_RATE_RESET;
         last_r_ff <= '0;
         last_l_ff <= '0;
         pose_x_ff <= '0;
         pose_y_ff <= '0;
         pose_h_ff <= '0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         pose_x_ff <= pose_x_in;
         pose_y_ff <= pose_y_in;
         pose_h_ff <= pose_h_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_METERS_PER_COUNT:   mpc_ff <= csr_write_data;
               CSR_INVERSE_WHEEL_BASE: iwb_ff <= csr_write_data;
               CSR_SAMPLE_RATE:        sr_ff <= csr_write_data[15:0];
               default:                mpc_ff <= mpc_ff;
            endcase
         end
         if (accept) begin
            last_r_ff <= req.right_count;
            last_l_ff <= req.left_count;
         end
      end
      if (accept) begin
         dr_ff <= dr_new;
         dl_ff <= dl_new;
         sum_ff <= dr_new + dl_new;
         diff_ff <= dr_new - dl_new;
      end
      scale_ff <= scale_in;
      turn_ff <= turn_in;
      dth_ff <= dth_in;
      dx_mag_ff <= dx_mag_in;
      rs_ff <= rs_in;
      ls_ff <= ls_in;
      lin_ff <= lin_in;
      ang_ff <= ang_in;
      if (load_out) begin
         o_x_ff <= pose_x_ff;
         o_y_ff <= pose_y_ff;
         o_h_ff <= pose_h_in;
         o_rs_ff <= rs_ff;
         o_ls_ff <= ls_ff;
         o_lin_ff <= lin_ff;
         o_ang_ff <= ang_ff;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.x_position = o_x_ff;
   assign rsp.y_position = o_y_ff;
   assign rsp.heading = o_h_ff;
   assign rsp.right_speed = o_rs_ff;
   assign rsp.left_speed = o_ls_ff;
   assign rsp.linear_speed = o_lin_ff;
   assign rsp.angular_speed = o_ang_ff;
endmodule

@@ rtl/ddo_checker.sv @@
// port-level checks of the odometry block, bound to the top level
module ddo_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [30:0] rsp_heading
);
   // a waiting response stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // busy right after a request is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready after request");

   // no response appears in the cycle after a request
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response too early");

   // heading wrapped into plus or minus pi
   a_heading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heading <= 31'sd843314857) && (rsp_heading >= -31'sd843314857))
      else $error("heading out of range");
endmodule

bind differential_drive_odometry_top ddo_checker u_ddo_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_heading (rsp.heading)
);
